// ===== hdl/spi_master_controller_unit_macros.svh =====
// Assertion macros for the SPI master controller unit.
`ifndef SPI_MASTER_CONTROLLER_UNIT_MACROS_SVH
`define SPI_MASTER_CONTROLLER_UNIT_MACROS_SVH

// Checked outside reset only.
`define SPIMC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spimc assertion failed");

// Checked in every cycle, reset included.
`define SPIMC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spimc assertion failed");

`endif

// ===== hdl/spimc_pkg.sv =====
`default_nettype none

package spimc_pkg;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_STARTED  = 3'd1,
        PH_SELECTED = 3'd2,
        PH_BUSY     = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    localparam logic [2:0] REG_CTRL = 3'd4;
    localparam logic [2:0] REG_DIV  = 3'd5;
    localparam logic [2:0] REG_SEL  = 3'd6;

    localparam int CTRL_GO_BIT  = 8;
    localparam int CTRL_LSB_BIT = 11;
    localparam int CTRL_ASS_BIT = 13;

    localparam logic [31:0] DIV_RESET = 32'h0000_ffff;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // result bit positions in m_tdata
    localparam int OUT_MOSI_BIT   = 32;
    localparam int OUT_STROBE_BIT = 33;
    localparam int OUT_SEL_LSB    = 34;
    localparam int OUT_BUSY_BIT   = 42;
    localparam int OUT_DONE_BIT   = 43;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic        miso_bit;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        mosi_bit;
        logic        shift_strobe;
        logic [7:0]  select_lines;
        logic        busy_res;
        logic        done_pulse;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/spimc_in_stage.sv =====
`default_nettype none

module spimc_in_stage (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [spimc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [spimc_pkg::S_TUSER_W-1:0]   s_tuser,
    input  wire logic                              advance,
    output logic                                   item_valid,
    output spimc_pkg::item_t                       item
);

    logic              valid_reg, valid_next;
    spimc_pkg::item_t  item_reg, item_next;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                item_next.req_type   = s_tuser;
                item_next.reg_index  = s_tdata[2:0];
                item_next.write_data = s_tdata[34:3];
                item_next.miso_bit   = s_tdata[35];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hdl/spimc_core.sv =====
`default_nettype none

module spimc_core #(
    parameter int NUM_SLAVES = 8,
    parameter int INIT_WAIT  = 3
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire spimc_pkg::item_t  item,
    output spimc_pkg::res_t        res
);

    localparam int CYC_W = $clog2(INIT_WAIT + 2);
    localparam logic [CYC_W-1:0] CYC_MAX  = CYC_W'(INIT_WAIT + 1);
    localparam logic [CYC_W-1:0] CYC_WAIT = CYC_W'(INIT_WAIT);
    localparam logic [7:0] SLAVE_MASK = 8'((9'd1 << NUM_SLAVES) - 9'd1);

    logic [127:0]       shift_reg, shift_next;
    logic [31:0]        ctrl_reg, ctrl_next;
    logic [31:0]        div_reg, div_next;
    logic [31:0]        sel_reg, sel_next;
    spimc_pkg::phase_t  phase_reg, phase_next;
    logic [16:0]        presc_reg, presc_next;
    logic [7:0]         bits_reg, bits_next;
    logic [CYC_W-1:0]   cyc_reg, cyc_next;

    logic [16:0]  limit;
    logic [6:0]   top;
    logic [7:0]   bits_dec;
    logic [127:0] shifted;
    logic         slaves_on;
    logic         lines_on;
    logic [31:0]  rd;
    logic         mosi, strobe, done;

    function automatic logic [7:0] xfer_len(input logic [6:0] len);
        xfer_len = (len == 7'd0) ? 8'd128 : {1'b0, len};
    endfunction

    always_comb begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        div_next   = div_reg;
        sel_next   = sel_reg;
        phase_next = phase_reg;
        presc_next = presc_reg;
        bits_next  = bits_reg;
        cyc_next   = cyc_reg;
        rd         = 32'd0;
        mosi       = 1'b0;
        strobe     = 1'b0;
        done       = 1'b0;

        limit     = {div_reg[15:0], 1'b1};
        top       = 7'(ctrl_reg[6:0] - 7'd1);
        bits_dec  = bits_reg - 8'd1;
        slaves_on = |(sel_reg[7:0] & SLAVE_MASK);

        if (ctrl_reg[spimc_pkg::CTRL_LSB_BIT]) begin
            shifted      = {1'b0, shift_reg[127:1]};
            shifted[top] = item.miso_bit;
        end else begin
            shifted = {shift_reg[126:0], item.miso_bit};
        end

        case (item.req_type)
            spimc_pkg::REQ_READ: begin
                if (!item.reg_index[2]) begin
                    rd = shift_reg[{item.reg_index[1:0], 5'd0} +: 32];
                end else begin
                    case (item.reg_index)
                        spimc_pkg::REG_CTRL: rd = ctrl_reg;
                        spimc_pkg::REG_DIV:  rd = div_reg;
                        spimc_pkg::REG_SEL:  rd = sel_reg;
                        default:             rd = 32'd0;
                    endcase
                end
            end
            spimc_pkg::REQ_WRITE: begin
                if (phase_reg == spimc_pkg::PH_IDLE) begin
                    if (!item.reg_index[2]) begin
                        shift_next[{item.reg_index[1:0], 5'd0} +: 32] = item.write_data;
                    end else begin
                        case (item.reg_index)
                            spimc_pkg::REG_CTRL: begin
                                ctrl_next = item.write_data;
                                if (item.write_data[spimc_pkg::CTRL_GO_BIT]) begin
                                    phase_next = spimc_pkg::PH_STARTED;
                                    bits_next  = xfer_len(item.write_data[6:0]);
                                end
                            end
                            spimc_pkg::REG_DIV: div_next = item.write_data;
                            spimc_pkg::REG_SEL: sel_next = item.write_data;
                            default: ;
                        endcase
                    end
                end
            end
            spimc_pkg::REQ_TICK: begin
                if (presc_reg >= limit) begin
                    presc_next = 17'd0;
                    if (cyc_reg < CYC_MAX) begin
                        cyc_next = cyc_reg + CYC_W'(1);
                    end
                    if (slaves_on) begin
                        case (phase_reg)
                            spimc_pkg::PH_STARTED: phase_next = spimc_pkg::PH_SELECTED;
                            spimc_pkg::PH_SELECTED: begin
                                if (cyc_reg > CYC_WAIT) begin
                                    phase_next = spimc_pkg::PH_BUSY;
                                end
                            end
                            spimc_pkg::PH_BUSY: begin
                                mosi       = ctrl_reg[spimc_pkg::CTRL_LSB_BIT] ?
                                             shift_reg[0] : shift_reg[top];
                                strobe     = 1'b1;
                                shift_next = shifted;
                                bits_next  = bits_dec;
                                if (bits_dec == 8'd0) begin
                                    phase_next = spimc_pkg::PH_DONE;
                                end
                            end
                            spimc_pkg::PH_DONE: begin
                                phase_next = spimc_pkg::PH_IDLE;
                                ctrl_next[spimc_pkg::CTRL_GO_BIT] = 1'b0;
                                done = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end else begin
                    presc_next = presc_reg + 17'd1;
                end
            end
            default: ;
        endcase

        lines_on = !ctrl_next[spimc_pkg::CTRL_ASS_BIT] ||
                   phase_next == spimc_pkg::PH_SELECTED ||
                   phase_next == spimc_pkg::PH_BUSY ||
                   phase_next == spimc_pkg::PH_DONE;

        res.read_data    = rd;
        res.mosi_bit     = mosi;
        res.shift_strobe = strobe;
        res.select_lines = lines_on ? (sel_next[7:0] & SLAVE_MASK) : 8'd0;
        res.busy_res     = phase_next != spimc_pkg::PH_IDLE;
        res.done_pulse   = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 128'd0;
            ctrl_reg  <= 32'd0;
            div_reg   <= spimc_pkg::DIV_RESET;
            sel_reg   <= 32'd0;
            phase_reg <= spimc_pkg::PH_IDLE;
            presc_reg <= 17'd0;
            bits_reg  <= 8'd0;
            cyc_reg   <= '0;
        end else if (fire) begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            div_reg   <= div_next;
            sel_reg   <= sel_next;
            phase_reg <= phase_next;
            presc_reg <= presc_next;
            bits_reg  <= bits_next;
            cyc_reg   <= cyc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/spimc_out_stage.sv =====
`default_nettype none

module spimc_out_stage (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              item_valid,
    input  wire spimc_pkg::res_t                   res,
    output logic                                   advance,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [spimc_pkg::M_TDATA_W-1:0]        m_tdata
);

    logic             valid_reg, valid_next;
    spimc_pkg::res_t  res_reg, res_next;

    assign advance = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (advance) begin
            valid_next = item_valid;
            if (item_valid) begin
                res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.done_pulse, res_reg.busy_res, res_reg.select_lines,
                       res_reg.shift_strobe, res_reg.mosi_bit, res_reg.read_data};

endmodule

`default_nettype wire

// ===== hdl/spi_master_controller_unit.sv =====
// channel | ports                              | contents
// --------+------------------------------------+---------------------------------------
// request | s_tvalid s_tready s_tdata s_tuser  | tuser: req_type; tdata: reg, data, miso
// result  | m_tvalid m_tready m_tdata          | one result per request
//
// One request per cycle unless m_tready stalls; path: input register, result register.
// All request work is one pass of logic between those registers; state updates as the
// request leaves the input register.
// aresetn is synchronous, active low; clears valid flags and core state, not stage data.
// A stalled result holds m_tdata; s_tready stays high while the input register can move.
`default_nettype none

module spi_master_controller_unit #(
    parameter int NUM_SLAVES = 8,
    parameter int INIT_WAIT  = 3
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] reg_index, [34:3] write_data, [35] miso_bit
    input  wire logic [spimc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  wire logic [spimc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] read_data, [32] mosi_bit, [33] shift_strobe, [41:34] select_lines,
    // [42] busy_res, [43] done_pulse
    output logic [spimc_pkg::M_TDATA_W-1:0]        m_tdata
);

    logic              advance;
    logic              item_valid;
    spimc_pkg::item_t  item;
    spimc_pkg::res_t   res;

    spimc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    spimc_core #(
        .NUM_SLAVES (NUM_SLAVES),
        .INIT_WAIT  (INIT_WAIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (item_valid && advance),
        .item    (item),
        .res     (res)
    );

    spimc_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .res        (res),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/spimc_checker.sv =====
`default_nettype none
`include "spi_master_controller_unit_macros.svh"

module spimc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [spimc_pkg::M_TDATA_W-1:0]   m_tdata
);

    `SPIMC_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)
    `SPIMC_ASSERT(a_stall_holds, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `SPIMC_ASSERT(a_empty_takes_request, aclk, aresetn, !m_tvalid |-> s_tready)
    `SPIMC_ASSERT(a_done_ends_busy, aclk, aresetn,
        m_tvalid && m_tdata[spimc_pkg::OUT_DONE_BIT] |-> !m_tdata[spimc_pkg::OUT_BUSY_BIT])
    `SPIMC_ASSERT(a_strobe_while_busy, aclk, aresetn,
        m_tvalid && m_tdata[spimc_pkg::OUT_STROBE_BIT] |-> m_tdata[spimc_pkg::OUT_BUSY_BIT])

endmodule

bind spi_master_controller_unit spimc_checker u_spimc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb_spi_master_controller_unit.sv =====
`timescale 1ns / 100ps

module tb_spi_master_controller_unit;

    localparam int NUM_SLAVES = 8;
    localparam int INIT_WAIT  = 3;
    localparam logic [7:0] SLAVE_MASK = 8'((1 << NUM_SLAVES) - 1);

    localparam logic [1:0] REQ_NOP   = 2'd3;
    localparam logic [2:0] REG_DATA0 = 3'd0;
    localparam logic [2:0] REG_DATA1 = 3'd1;
    localparam logic [2:0] REG_DATA2 = 3'd2;
    localparam logic [2:0] REG_DATA3 = 3'd3;
    localparam logic [2:0] REG_NONE  = 3'd7;

    localparam int RAND_ITEMS   = 250;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    localparam int TX_IDLE_PCT [3] = '{34, 76, 0};
    localparam int RX_IDLE_PCT [3] = '{76, 34, 0};

    typedef struct {
        logic [1:0]  req;
        logic [2:0]  idx;
        logic [31:0] data;
        logic        miso;
        int          reps;
        bit          typed;
        logic [31:0] want_rd;
    } stim_row_t;

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [spimc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [spimc_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [spimc_pkg::M_TDATA_W-1:0] m_tdata;

    // predicted controller state
    logic [127:0]       sr_q;
    logic [31:0]        ctrl_q;
    logic [31:0]        div_q;
    logic [31:0]        sel_q;
    spimc_pkg::phase_t  ph_q;
    logic [16:0]        presc_q;
    logic [7:0]         bits_q;
    logic [2:0]         slow_q;

    spimc_pkg::res_t  res_expected [$];
    stim_row_t        dir_tab [$];
    int               n_err       = 0;
    int               n_sent      = 0;
    int               n_results   = 0;
    int               hold_left   = 0;
    int               idle_mode   = 0;
    int unsigned      cycle_count = 0;

    spi_master_controller_unit #(
        .NUM_SLAVES (NUM_SLAVES),
        .INIT_WAIT  (INIT_WAIT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic clear_master();
        sr_q    = '0;
        ctrl_q  = '0;
        div_q   = spimc_pkg::DIV_RESET;
        sel_q   = '0;
        ph_q    = spimc_pkg::PH_IDLE;
        presc_q = '0;
        bits_q  = '0;
        slow_q  = '0;
    endtask

    function automatic spimc_pkg::res_t step_master(logic [1:0] req, logic [2:0] idx,
                                                    logic [31:0] data, logic miso);
        spimc_pkg::res_t r;
        logic [6:0]      top;
        logic [2:0]      cyc;
        r   = '0;
        top = ctrl_q[6:0] - 7'd1;   // length 0 wraps to bit 127
        case (req)
            spimc_pkg::REQ_READ: begin
                if (idx < spimc_pkg::REG_CTRL) r.read_data = sr_q[32*idx +: 32];
                else if (idx == spimc_pkg::REG_CTRL) r.read_data = ctrl_q;
                else if (idx == spimc_pkg::REG_DIV) r.read_data = div_q;
                else if (idx == spimc_pkg::REG_SEL) r.read_data = sel_q;
            end
            spimc_pkg::REQ_WRITE: begin
                if (ph_q == spimc_pkg::PH_IDLE) begin
                    if (idx < spimc_pkg::REG_CTRL) begin
                        sr_q[32*idx +: 32] = data;
                    end else if (idx == spimc_pkg::REG_CTRL) begin
                        ctrl_q = data;
                        if (data[spimc_pkg::CTRL_GO_BIT]) begin
                            ph_q   = spimc_pkg::PH_STARTED;
                            bits_q = (data[6:0] == 7'd0) ? 8'd128 : {1'b0, data[6:0]};
                        end
                    end else if (idx == spimc_pkg::REG_DIV) begin
                        div_q = data;
                    end else if (idx == spimc_pkg::REG_SEL) begin
                        sel_q = data;
                    end
                end
            end
            spimc_pkg::REQ_TICK: begin
                if (presc_q >= {div_q[15:0], 1'b1}) begin
                    cyc = slow_q;
                    if ((sel_q[7:0] & SLAVE_MASK) != 8'd0) begin
                        case (ph_q)
                            spimc_pkg::PH_STARTED: ph_q = spimc_pkg::PH_SELECTED;
                            spimc_pkg::PH_SELECTED: begin
                                if (cyc > INIT_WAIT) ph_q = spimc_pkg::PH_BUSY;
                            end
                            spimc_pkg::PH_BUSY: begin
                                if (ctrl_q[spimc_pkg::CTRL_LSB_BIT]) begin
                                    r.mosi_bit = sr_q[0];
                                    sr_q       = sr_q >> 1;
                                    sr_q[top]  = miso;
                                end else begin
                                    r.mosi_bit = sr_q[top];
                                    sr_q       = sr_q << 1;
                                    sr_q[0]    = miso;
                                end
                                r.shift_strobe = 1'b1;
                                bits_q = bits_q - 8'd1;
                                if (bits_q == 8'd0) ph_q = spimc_pkg::PH_DONE;
                            end
                            spimc_pkg::PH_DONE: begin
                                ph_q                           = spimc_pkg::PH_IDLE;
                                ctrl_q[spimc_pkg::CTRL_GO_BIT] = 1'b0;
                                r.done_pulse                   = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    if (slow_q < INIT_WAIT + 1) slow_q = slow_q + 3'd1;
                    presc_q = '0;
                end else begin
                    presc_q = presc_q + 17'd1;
                end
            end
            default: ;
        endcase
        if (ctrl_q[spimc_pkg::CTRL_ASS_BIT])
            r.select_lines = (ph_q == spimc_pkg::PH_SELECTED || ph_q == spimc_pkg::PH_BUSY ||
                              ph_q == spimc_pkg::PH_DONE)
                             ? (sel_q[7:0] & SLAVE_MASK) : 8'd0;
        else
            r.select_lines = sel_q[7:0] & SLAVE_MASK;
        r.busy_res = (ph_q != spimc_pkg::PH_IDLE);
        return r;
    endfunction

    task automatic offer_req(logic [1:0] req, logic [2:0] idx, logic [31:0] data,
                             logic miso, bit typed = 1'b0, logic [31:0] want_rd = '0);
        spimc_pkg::res_t pred;
        while ($urandom_range(0, 99) < TX_IDLE_PCT[idle_mode]) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(spimc_pkg::S_TDATA_W-36){1'b0}}, miso, data, idx};
        do @(posedge aclk); while (!s_tready);
        pred = step_master(req, idx, data, miso);
        if (typed) pred = '{read_data: want_rd, default: '0};
        res_expected.push_back(pred);
        n_sent++;
    endtask

    function automatic stim_row_t stim_row(logic [1:0] req, logic [2:0] idx,
                                           logic [31:0] data, logic miso, int reps,
                                           bit typed, logic [31:0] want_rd);
        stim_row_t r;
        r.req     = req;
        r.idx     = idx;
        r.data    = data;
        r.miso    = miso;
        r.reps    = reps;
        r.typed   = typed;
        r.want_rd = want_rd;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            n_err++;
        end
    endfunction

    // result side: compare against oldest prediction, random stalls, one long hold-off
    always @(posedge aclk) begin
        spimc_pkg::res_t want;
        if (m_tvalid && m_tready) begin
            if (res_expected.size() == 0) begin
                $error("result with no request pending: %h", m_tdata);
                n_err++;
            end else begin
                want = res_expected.pop_front();
                check_field("read_data", want.read_data, m_tdata[31:0]);
                check_field("mosi_bit", 32'(want.mosi_bit),
                            32'(m_tdata[spimc_pkg::OUT_MOSI_BIT]));
                check_field("shift_strobe", 32'(want.shift_strobe),
                            32'(m_tdata[spimc_pkg::OUT_STROBE_BIT]));
                check_field("select_lines", 32'(want.select_lines),
                            32'(m_tdata[spimc_pkg::OUT_SEL_LSB +: 8]));
                check_field("busy_res", 32'(want.busy_res),
                            32'(m_tdata[spimc_pkg::OUT_BUSY_BIT]));
                check_field("done_pulse", 32'(want.done_pulse),
                            32'(m_tdata[spimc_pkg::OUT_DONE_BIT]));
            end
            n_results++;
            if (n_results == HOLD_AT) hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= RX_IDLE_PCT[idle_mode]);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int          k;
        int          n;
        int          p;
        int          seq_no;
        int          base;
        logic [31:0] d;
        logic [31:0] c;
        logic [6:0]  len;
        logic [1:0]  rq;
        logic [2:0]  ix;

        clear_master();

        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, spimc_pkg::REG_DIV, '0, 1'b0, 1,
                                   1'b1, spimc_pkg::DIV_RESET));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, spimc_pkg::REG_CTRL, '0, 1'b0, 1,
                                   1'b1, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, REG_NONE, '0, 1'b0, 1, 1'b1, '0));
        dir_tab.push_back(stim_row(REQ_NOP, REG_NONE, '1, 1'b1, 1, 1'b1, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, REG_NONE, '1, 1'b1, 1, 1'b1, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, spimc_pkg::REG_DIV, '1, 1'b0, 1,
                                   1'b1, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, spimc_pkg::REG_DIV, '0, 1'b0, 1,
                                   1'b1, '1));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, spimc_pkg::REG_DIV, '0, 1'b0, 1,
                                   1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, REG_DATA0, '1, 1'b0, 1, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, REG_DATA1, '0, 1'b0, 1, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, REG_DATA2, 32'ha5a5_a5a5, 1'b0, 1,
                                   1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, REG_DATA3, 32'h8000_0001, 1'b0, 1,
                                   1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, spimc_pkg::REG_SEL, 32'hffff_ff01,
                                   1'b0, 1, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, spimc_pkg::REG_SEL, '0, 1'b0, 1,
                                   1'b0, '0));
        // lsb-first, auto select, 2 bits; first transfer sits out the init wait
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, spimc_pkg::REG_CTRL,
            32'((1 << spimc_pkg::CTRL_ASS_BIT) | (1 << spimc_pkg::CTRL_LSB_BIT) |
                (1 << spimc_pkg::CTRL_GO_BIT) | 2),
            1'b0, 1, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_TICK, REG_DATA0, '0, 1'b1, 10, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, REG_DATA0, 32'h1234_5678, 1'b0, 1,
                                   1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, spimc_pkg::REG_CTRL, '0, 1'b0, 1,
                                   1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_TICK, REG_NONE, '1, 1'b0, 6, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, REG_DATA0, '0, 1'b0, 1, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, REG_DATA3, '0, 1'b0, 1, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, spimc_pkg::REG_CTRL, '0, 1'b0, 1,
                                   1'b0, '0));
        // msb-first, select always on, 3 bits
        dir_tab.push_back(stim_row(spimc_pkg::REQ_WRITE, spimc_pkg::REG_CTRL,
            32'((1 << spimc_pkg::CTRL_GO_BIT) | 3), 1'b0, 1, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_TICK, REG_DATA0, '0, 1'b1, 12, 1'b0, '0));
        dir_tab.push_back(stim_row(spimc_pkg::REQ_READ, REG_DATA0, '0, 1'b0, 1, 1'b0, '0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            for (k = 0; k < dir_tab[i].reps; k++)
                offer_req(dir_tab[i].req, dir_tab[i].idx, dir_tab[i].data, dir_tab[i].miso,
                          dir_tab[i].typed, dir_tab[i].want_rd);

        base   = n_sent;
        seq_no = 0;
        while (n_sent - base < RAND_ITEMS) begin
            if (n_sent - base < RAND_ITEMS / 3) idle_mode = 0;
            else if (n_sent - base < 2 * RAND_ITEMS / 3) idle_mode = 1;
            else idle_mode = 2;

            p = $urandom_range(0, 99);
            if (seq_no == 1) len = 7'd0;
            else if (p < 5) len = 7'($urandom_range(13, 100));
            else len = 7'($urandom_range(1, 12));

            n = $urandom_range(0, 4);
            for (k = 0; k < n; k++)
                offer_req(spimc_pkg::REQ_WRITE, 3'($urandom_range(0, 3)), $urandom,
                          1'($urandom));
            if (len == 7'd0 || len > 7'd12 || $urandom_range(0, 1) == 1) begin
                d = $urandom;
                d[15:0] = (len == 7'd0 || len > 7'd12) ? 16'd0 : 16'($urandom_range(0, 3));
                offer_req(spimc_pkg::REQ_WRITE, spimc_pkg::REG_DIV, d, 1'($urandom));
            end
            if (sel_q[7:0] == 8'd0 || $urandom_range(0, 1) == 1) begin
                d = $urandom;
                if (d[7:0] == 8'd0) d[$urandom_range(0, 7)] = 1'b1;
                offer_req(spimc_pkg::REQ_WRITE, spimc_pkg::REG_SEL, d, 1'($urandom));
            end
            c = $urandom;
            c[6:0] = len;
            c[spimc_pkg::CTRL_GO_BIT] = (seq_no == 1) || ($urandom_range(0, 9) != 0);
            offer_req(spimc_pkg::REQ_WRITE, spimc_pkg::REG_CTRL, c, 1'($urandom));

            while (ph_q != spimc_pkg::PH_IDLE) begin
                p = $urandom_range(0, 99);
                if (p < 80)
                    offer_req(spimc_pkg::REQ_TICK, 3'($urandom), $urandom, 1'($urandom));
                else if (p < 88)
                    offer_req(spimc_pkg::REQ_READ, 3'($urandom), $urandom, 1'($urandom));
                else if (p < 96)
                    offer_req(spimc_pkg::REQ_WRITE, 3'($urandom), $urandom, 1'($urandom));
                else
                    offer_req(REQ_NOP, 3'($urandom), $urandom, 1'($urandom));
            end
            for (k = 0; k < 4; k++)
                offer_req(spimc_pkg::REQ_READ, 3'(k), $urandom, 1'($urandom));

            // noise between transfers
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
                rq = 2'($urandom);
                ix = 3'($urandom);
                d  = $urandom;
                if (rq == spimc_pkg::REQ_WRITE && ix == spimc_pkg::REG_DIV)
                    d[15:0] = 16'($urandom_range(0, 3));
                if (rq == spimc_pkg::REQ_WRITE && ix == spimc_pkg::REG_CTRL &&
                    (sel_q[7:0] == 8'd0 || $urandom_range(0, 4) != 0))
                    d[spimc_pkg::CTRL_GO_BIT] = 1'b0;
                offer_req(rq, ix, d, 1'($urandom));
            end
            seq_no++;
        end

        while (ph_q != spimc_pkg::PH_IDLE)
            offer_req(spimc_pkg::REQ_TICK, 3'($urandom), $urandom, 1'($urandom));

        // no slave line selected: the transfer must stall in started
        offer_req(spimc_pkg::REQ_WRITE, spimc_pkg::REG_SEL, 32'h0000_0100, 1'b0);
        offer_req(spimc_pkg::REQ_WRITE, spimc_pkg::REG_CTRL,
                  32'((1 << spimc_pkg::CTRL_ASS_BIT) | (1 << spimc_pkg::CTRL_GO_BIT) | 4),
                  1'b0);
        for (k = 0; k < 12; k++)
            offer_req(spimc_pkg::REQ_TICK, 3'($urandom), $urandom, 1'($urandom));
        offer_req(spimc_pkg::REQ_READ, spimc_pkg::REG_CTRL, '0, 1'b0);
        s_tvalid <= 1'b0;

        while (res_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
